FILE: hw/rtl/cascade_pid_position_rate_defines.svh
// Assertion macros for the cascade position/rate controller.
`ifndef CASCADE_PID_POSITION_RATE_DEFINES_SVH
`define CASCADE_PID_POSITION_RATE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define CPR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CPR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cpr_pkg.sv
// Shared widths, codes, control types and arithmetic helpers of the cascade controller.
package cpr_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int POS_W          = 16;
    localparam int ERR_W          = 17;
    localparam int DIFF_W         = 18;
    localparam int INT_W          = 32;
    localparam int ACC_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTER_KP          = 3'd0,
        REG_OUTER_KI          = 3'd1,
        REG_OUTER_KD          = 3'd2,
        REG_INNER_KP          = 3'd3,
        REG_INNER_KI          = 3'd4,
        REG_INNER_KD          = 3'd5,
        REG_OUTER_ERROR_LIMIT = 3'd6,
        REG_INTEGRAL_LIMIT    = 3'd7
    } cfg_reg_t;

    // Sequencer controls for the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctl_t;

    localparam logic signed [INT_W:0] INT_MAX_X = {2'b00, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W:0] INT_MIN_X = {2'b11, {(INT_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0]  ACC_POS_MAX  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  ACC_POS_MIN  = ACC_W'(-32768);
    localparam logic signed [DIFF_W-1:0] DIFF_POS_MAX = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0] DIFF_POS_MIN = DIFF_W'(-32768);

    // Add error to integral, saturate to 32 bits, then clamp from above
    function automatic logic signed [INT_W-1:0] integrate(
        input logic signed [INT_W-1:0] acc,
        input logic signed [ERR_W-1:0] err,
        input logic signed [INT_W-1:0] limit
    );
        logic signed [INT_W:0]   sum;
        logic signed [INT_W-1:0] res;
        sum = {acc[INT_W-1], acc} + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (sum > INT_MAX_X)
            res = INT_MAX_X[INT_W-1:0];
        else if (sum < INT_MIN_X)
            res = INT_MIN_X[INT_W-1:0];
        else
            res = sum[INT_W-1:0];
        if (res > limit)
            res = limit;
        return res;
    endfunction

    // Floor-shift the accumulated sum and saturate to 16 bits
    function automatic logic signed [POS_W-1:0] scale_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] shifted;
        logic signed [POS_W-1:0] res;
        shifted = acc >>> GAIN_FRAC_BITS;
        if (shifted > ACC_POS_MAX)
            res = ACC_POS_MAX[POS_W-1:0];
        else if (shifted < ACC_POS_MIN)
            res = ACC_POS_MIN[POS_W-1:0];
        else
            res = shifted[POS_W-1:0];
        return res;
    endfunction

    // Saturate an error change to 16 bits
    function automatic logic signed [POS_W-1:0] diff_sat(
        input logic signed [DIFF_W-1:0] d
    );
        logic signed [POS_W-1:0] res;
        if (d > DIFF_POS_MAX)
            res = DIFF_POS_MAX[POS_W-1:0];
        else if (d < DIFF_POS_MIN)
            res = DIFF_POS_MIN[POS_W-1:0];
        else
            res = d[POS_W-1:0];
        return res;
    endfunction

endpackage

FILE: hw/rtl/cpr_in_if.sv
// Request channel carrying one position sample.
interface cpr_in_if
    import cpr_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] target_position;
    logic signed [POS_W-1:0] measured_position;

    modport source (output valid, output target_position, output measured_position,
                    input ready);
    modport sink   (input valid, input target_position, input measured_position,
                    output ready);
endinterface

FILE: hw/rtl/cpr_out_if.sv
// Result channel carrying the drive value and the outer loop output.
interface cpr_out_if
    import cpr_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] drive_value;
    logic signed [POS_W-1:0] outer_output;

    modport source (output valid, output drive_value, output outer_output, input ready);
    modport sink   (input valid, input drive_value, input outer_output, output ready);
endinterface

FILE: hw/rtl/cpr_mac.sv
// Shared signed multiply-accumulate unit with a registered product.
module cpr_mac
    import cpr_pkg::*;
(
    input  logic                     clk,
    input  mac_ctl_t                 ctl,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic signed [INT_W-1:0]  operand,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Register the product, then fold it into the sum
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= gain * operand;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hw/rtl/cascade_pid_position_rate.sv
// Cascade position/rate PID: sequencer, loop state and configuration registers.
// An accepted request passes through the outer error, integral, multiply and finish states, then the inner ones.
// A new request is taken only after the previous result has been taken on the result channel.
// The single 16x32 multiplier computes the six gain products in sequence.
// Reset: gains and limits take their default values, errors and integrals clear.
module cascade_pid_position_rate
    import cpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cpr_in_if.sink                in_ch,
    cpr_out_if.source             out_ch,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "cascade_pid_position_rate_defines.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_O_ERR,
        ST_O_INT,
        ST_O_MUL,
        ST_O_FIN,
        ST_I_ERR,
        ST_I_INT,
        ST_I_MUL,
        ST_I_FIN,
        ST_OUT
    } state_t;

    localparam logic [1:0] TERM_P     = 2'd0;
    localparam logic [1:0] TERM_I     = 2'd1;
    localparam logic [1:0] TERM_D     = 2'd2;
    localparam logic [1:0] TERM_DRAIN = 2'd3;

    state_t state_reg;
    state_t state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    logic signed [GAIN_W-1:0] outer_kp_reg;
    logic signed [GAIN_W-1:0] outer_ki_reg;
    logic signed [GAIN_W-1:0] outer_kd_reg;
    logic signed [GAIN_W-1:0] inner_kp_reg;
    logic signed [GAIN_W-1:0] inner_ki_reg;
    logic signed [GAIN_W-1:0] inner_kd_reg;
    logic signed [ERR_W-1:0]  outer_error_limit_reg;
    logic signed [INT_W-1:0]  integral_limit_reg;

    logic signed [ERR_W-1:0] outer_err_reg;
    logic signed [ERR_W-1:0] outer_prev_reg;
    logic signed [INT_W-1:0] outer_int_reg;
    logic signed [ERR_W-1:0] inner_err_reg;
    logic signed [ERR_W-1:0] inner_prev_reg;
    logic signed [INT_W-1:0] inner_int_reg;

    logic signed [POS_W-1:0]  target_reg;
    logic signed [POS_W-1:0]  measured_reg;
    logic signed [DIFF_W-1:0] delta_reg;
    logic signed [POS_W-1:0]  outer_out_reg;
    logic signed [POS_W-1:0]  drive_reg;

    logic                     in_loop_inner;
    logic                     in_accept;
    logic signed [ERR_W-1:0]  pos_diff;
    logic signed [ERR_W-1:0]  outer_err_clamped;
    logic signed [ERR_W-1:0]  inner_err_new;
    logic signed [INT_W-1:0]  int_sel;
    logic signed [ERR_W-1:0]  err_sel;
    logic signed [ERR_W-1:0]  prev_sel;
    logic signed [INT_W-1:0]  int_new;
    logic signed [DIFF_W-1:0] delta_new;
    logic signed [GAIN_W-1:0] mac_gain;
    logic signed [INT_W-1:0]  mac_operand;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [POS_W-1:0]  loop_out;
    mac_ctl_t                 mac_ctl;

    // Handshake
    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign in_accept           = in_ch.valid && in_ch.ready;
    assign out_ch.valid        = (state_reg == ST_OUT);
    assign out_ch.drive_value  = drive_reg;
    assign out_ch.outer_output = outer_out_reg;

    assign in_loop_inner = (state_reg == ST_I_ERR) || (state_reg == ST_I_INT) ||
                           (state_reg == ST_I_MUL) || (state_reg == ST_I_FIN);

    // Outer error, clamped from above only
    assign pos_diff = {target_reg[POS_W-1], target_reg} -
                      {measured_reg[POS_W-1], measured_reg};
    assign outer_err_clamped = (pos_diff > outer_error_limit_reg) ? outer_error_limit_reg
                                                                  : pos_diff;

    // Inner error: outer output minus saturated outer error change
    always_comb
    begin
        logic signed [POS_W-1:0] meas_sat;
        meas_sat      = diff_sat(delta_reg);
        inner_err_new = {outer_out_reg[POS_W-1], outer_out_reg} -
                        {meas_sat[POS_W-1], meas_sat};
    end

    // Shared integral update and error change for the active loop
    assign int_sel   = in_loop_inner ? inner_int_reg  : outer_int_reg;
    assign err_sel   = in_loop_inner ? inner_err_reg  : outer_err_reg;
    assign prev_sel  = in_loop_inner ? inner_prev_reg : outer_prev_reg;
    assign int_new   = integrate(int_sel, err_sel, integral_limit_reg);
    assign delta_new = {err_sel[ERR_W-1], err_sel} - {prev_sel[ERR_W-1], prev_sel};

    // Select gain and operand for the current term
    always_comb
    begin
        case (cnt_reg)
            TERM_P:
            begin
                mac_gain    = in_loop_inner ? inner_kp_reg : outer_kp_reg;
                mac_operand = {{(INT_W-ERR_W){err_sel[ERR_W-1]}}, err_sel};
            end
            TERM_I:
            begin
                mac_gain    = in_loop_inner ? inner_ki_reg : outer_ki_reg;
                mac_operand = int_sel;
            end
            TERM_D:
            begin
                mac_gain    = in_loop_inner ? inner_kd_reg : outer_kd_reg;
                mac_operand = {{(INT_W-DIFF_W){delta_reg[DIFF_W-1]}}, delta_reg};
            end
            default:
            begin
                mac_gain    = '0;
                mac_operand = '0;
            end
        endcase
    end

    // Drive the multiply-accumulate unit
    always_comb
    begin
        mac_ctl.clear  = (state_reg == ST_O_ERR) || (state_reg == ST_I_ERR);
        mac_ctl.mul_en = ((state_reg == ST_O_MUL) || (state_reg == ST_I_MUL)) &&
                         (cnt_reg != TERM_DRAIN);
        mac_ctl.acc_en = ((state_reg == ST_O_MUL) || (state_reg == ST_I_MUL)) &&
                         (cnt_reg != TERM_P);
    end

    cpr_mac u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .gain    (mac_gain),
        .operand (mac_operand),
        .acc     (mac_acc)
    );

    assign loop_out = scale_sat(mac_acc);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_O_ERR;
            end
            ST_O_ERR: state_next = ST_O_INT;
            ST_O_INT:
            begin
                state_next = ST_O_MUL;
                cnt_next   = TERM_P;
            end
            ST_O_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == TERM_DRAIN)
                    state_next = ST_O_FIN;
            end
            ST_O_FIN: state_next = ST_I_ERR;
            ST_I_ERR: state_next = ST_I_INT;
            ST_I_INT:
            begin
                state_next = ST_I_MUL;
                cnt_next   = TERM_P;
            end
            ST_I_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == TERM_DRAIN)
                    state_next = ST_I_FIN;
            end
            ST_I_FIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and loop memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= TERM_P;
            outer_err_reg  <= '0;
            outer_prev_reg <= '0;
            outer_int_reg  <= '0;
            inner_err_reg  <= '0;
            inner_prev_reg <= '0;
            inner_int_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            case (state_reg)
                ST_O_ERR:
                begin
                    outer_prev_reg <= outer_err_reg;
                    outer_err_reg  <= outer_err_clamped;
                end
                ST_O_INT: outer_int_reg <= int_new;
                ST_I_ERR:
                begin
                    inner_prev_reg <= inner_err_reg;
                    inner_err_reg  <= inner_err_new;
                end
                ST_I_INT: inner_int_reg <= int_new;
                default:
                begin
                end
            endcase
        end
    end

    // Capture the request, error change and loop outputs
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            target_reg   <= in_ch.target_position;
            measured_reg <= in_ch.measured_position;
        end
        if ((state_reg == ST_O_INT) || (state_reg == ST_I_INT))
        begin
            delta_reg <= delta_new;
        end
        if (state_reg == ST_O_FIN)
        begin
            outer_out_reg <= loop_out;
        end
        if (state_reg == ST_I_FIN)
        begin
            drive_reg <= loop_out;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_kp_reg          <= 16'sd7680;
            outer_ki_reg          <= 16'sd256;
            outer_kd_reg          <= 16'sd1536;
            inner_kp_reg          <= 16'sd7680;
            inner_ki_reg          <= 16'sd205;
            inner_kd_reg          <= 16'sd1536;
            outer_error_limit_reg <= 17'sd3;
            integral_limit_reg    <= 32'sd300;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OUTER_KP:          outer_kp_reg          <= cfg_data[GAIN_W-1:0];
                REG_OUTER_KI:          outer_ki_reg          <= cfg_data[GAIN_W-1:0];
                REG_OUTER_KD:          outer_kd_reg          <= cfg_data[GAIN_W-1:0];
                REG_INNER_KP:          inner_kp_reg          <= cfg_data[GAIN_W-1:0];
                REG_INNER_KI:          inner_ki_reg          <= cfg_data[GAIN_W-1:0];
                REG_INNER_KD:          inner_kd_reg          <= cfg_data[GAIN_W-1:0];
                REG_OUTER_ERROR_LIMIT: outer_error_limit_reg <= cfg_data[ERR_W-1:0];
                REG_INTEGRAL_LIMIT:    integral_limit_reg    <= cfg_data[INT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Checks
    `CPR_ASSERT_ALWAYS(a_ready_excl_valid, !(in_ch.ready && out_ch.valid), "ready while result pending")
    `CPR_ASSERT_IMPLY(a_result_after_inner, $rose(out_ch.valid), $past(state_reg == ST_I_FIN), "result without inner pass")
    `CPR_ASSERT_IMPLY(a_acc_clear_start, ((state_reg == ST_O_MUL) || (state_reg == ST_I_MUL)) && (cnt_reg == TERM_P), mac_acc == '0, "sum not cleared at loop start")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cascade position/rate PID controller.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cpr_pkg::*;

    localparam int     REG_COUNT       = 8;
    localparam int     SETTLE_CYCLES   = 20;
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     RANDOM_PHASES   = 12;
    localparam int     PHASE_SAMPLES   = 108;
    localparam int     SATURATION_RUN  = 32;
    localparam int     REPORT_LIMIT    = 10;
    localparam longint INT32_TOP       = 64'sh7fff_ffff;
    localparam longint INT32_BOTTOM    = -64'sh8000_0000;
    localparam longint WORD_TOP        = 32767;
    localparam longint WORD_BOTTOM     = -32768;

    typedef struct packed {
        logic signed [POS_W-1:0] drive_value;
        logic signed [POS_W-1:0] outer_output;
    } loop_result_t;

    // Tracks gains, limits and both loop states; predicts one result per request
    class pid_loop_tracker;
        logic signed [GAIN_W-1:0] okp, oki, okd, ikp, iki, ikd;
        logic signed [ERR_W-1:0]  err_limit;
        logic signed [INT_W-1:0]  int_limit;
        logic signed [ERR_W-1:0]  outer_err, outer_err_prev, inner_err, inner_err_prev;
        logic signed [INT_W-1:0]  outer_acc, inner_acc;
        loop_result_t             pending_results[$];
        int                       mismatches;

        function new();
            okp = 16'sd7680;
            oki = 16'sd256;
            okd = 16'sd1536;
            ikp = 16'sd7680;
            iki = 16'sd205;
            ikd = 16'sd1536;
            err_limit = 17'sd3;
            int_limit = 32'sd300;
            outer_err = '0;
            outer_err_prev = '0;
            inner_err = '0;
            inner_err_prev = '0;
            outer_acc = '0;
            inner_acc = '0;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
            case (r)
                REG_OUTER_KP:          okp = data[GAIN_W-1:0];
                REG_OUTER_KI:          oki = data[GAIN_W-1:0];
                REG_OUTER_KD:          okd = data[GAIN_W-1:0];
                REG_INNER_KP:          ikp = data[GAIN_W-1:0];
                REG_INNER_KI:          iki = data[GAIN_W-1:0];
                REG_INNER_KD:          ikd = data[GAIN_W-1:0];
                REG_OUTER_ERROR_LIMIT: err_limit = data[ERR_W-1:0];
                REG_INTEGRAL_LIMIT:    int_limit = data[INT_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function longint clip_word(longint v);
            if (v > WORD_TOP)
                return WORD_TOP;
            if (v < WORD_BOTTOM)
                return WORD_BOTTOM;
            return v;
        endfunction

        // Saturate to 32 bits first, then apply the shared upper clamp
        function logic signed [INT_W-1:0] accumulate_error(logic signed [INT_W-1:0] acc,
                                                          logic signed [ERR_W-1:0] e);
            longint s;
            s = longint'(acc) + longint'(e);
            if (s > INT32_TOP)
                s = INT32_TOP;
            else if (s < INT32_BOTTOM)
                s = INT32_BOTTOM;
            if (s > longint'(int_limit))
                s = int_limit;
            return s[INT_W-1:0];
        endfunction

        function void note_sample(logic signed [POS_W-1:0] tgt, logic signed [POS_W-1:0] meas);
            longint       err, sum, outer_out, inner_meas, drive;
            loop_result_t r;
            // outer position loop, error clamped from above only
            outer_err_prev = outer_err;
            err = longint'(tgt) - longint'(meas);
            if (err > longint'(err_limit))
                err = err_limit;
            outer_err = err[ERR_W-1:0];
            outer_acc = accumulate_error(outer_acc, outer_err);
            sum = longint'(okp) * longint'(outer_err) + longint'(oki) * longint'(outer_acc)
                + longint'(okd) * (longint'(outer_err) - longint'(outer_err_prev));
            outer_out = clip_word(sum >>> GAIN_FRAC_BITS);
            // inner loop: outer output is the target, error change the measurement
            inner_meas = clip_word(longint'(outer_err) - longint'(outer_err_prev));
            inner_err_prev = inner_err;
            err = outer_out - inner_meas;
            inner_err = err[ERR_W-1:0];
            inner_acc = accumulate_error(inner_acc, inner_err);
            sum = longint'(ikp) * longint'(inner_err) + longint'(iki) * longint'(inner_acc)
                + longint'(ikd) * (longint'(inner_err) - longint'(inner_err_prev));
            drive = clip_word(sum >>> GAIN_FRAC_BITS);
            r.drive_value = drive[POS_W-1:0];
            r.outer_output = outer_out[POS_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void flag(string what, longint expected, longint actual);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%t: %s expected %0d got %0d", $time, what, expected, actual);
        endfunction

        function void check_outputs(logic signed [POS_W-1:0] drive,
                                    logic signed [POS_W-1:0] outer);
            loop_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t: result with nothing pending, drive_value %0d outer_output %0d",
                             $time, drive, outer);
                return;
            end
            want = pending_results.pop_front();
            if (want.drive_value !== drive)
                flag("drive_value", want.drive_value, drive);
            if (want.outer_output !== outer)
                flag("outer_output", want.outer_output, outer);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    tx_gap_max = 7;
    int                    rx_gap_max = 7;
    int                    stalled_cycles = 0;
    pid_loop_tracker       tracker = new();

    cpr_in_if  in_ch();
    cpr_out_if out_ch();

    cascade_pid_position_rate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Opening samples {target, measured} at reset gains and limits
    logic [31:0] opening_samples[$] = '{
        32'h0000_0000, 32'h7fff_8000, 32'h8000_7fff, 32'h7fff_8000, 32'h8000_7fff,
        32'h8000_8000, 32'h7fff_7fff, 32'h0001_0000, 32'h0000_0001, 32'hffff_ffff,
        32'h0064_ff9c, 32'hff38_0032, 32'h0002_ffff, 32'h8000_0000, 32'h0000_8000
    };
    logic [31:0] corner_samples[$] = '{
        32'h7fff_8000, 32'h8000_7fff, 32'h0000_0000, 32'hffff_0000
    };
    logic [31:0] top_settings[REG_COUNT] = '{
        32'h0000_7fff, 32'h0000_7fff, 32'h0000_7fff, 32'h0000_7fff,
        32'h0000_7fff, 32'h0000_7fff, 32'h0000_ffff, 32'h7fff_ffff
    };
    // Most negative gains and limits: both clamps force values down
    logic [31:0] bottom_settings[REG_COUNT] = '{
        32'hffff_8000, 32'hffff_8000, 32'hffff_8000, 32'hffff_8000,
        32'hffff_8000, 32'hffff_8000, 32'h0001_0000, 32'h8000_0000
    };
    // Only the outer integral reaches the outer output; error pinned at -65536
    logic [31:0] saturation_settings[REG_COUNT] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_1e00,
        32'h0000_00cd, 32'h0000_0600, 32'h0001_0000, 32'h0000_0000
    };

    // Check every accepted request and result
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_sample(in_ch.target_position, in_ch.measured_position);
            if (out_ch.valid && out_ch.ready)
                tracker.check_outputs(out_ch.drive_value, out_ch.outer_output);
        end
    end

    // Stop the run when no handshake completes for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stalled_cycles <= 0;
        else if (stalled_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // Result side: random stall before each result
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic wait_until_idle();
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold valid until the request is taken; optionally drain all results first
    task automatic send_sample(logic [POS_W-1:0] tgt, logic [POS_W-1:0] meas, int gap,
                               bit drain_first);
        if (drain_first && gap == 0)
            gap = 1;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain_first) begin
                while (tracker.outstanding() != 0)
                    @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.target_position <= tgt;
        in_ch.measured_position <= meas;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_list(logic [31:0] samples[$]);
        foreach (samples[i])
            send_sample(samples[i][31:16], samples[i][15:0], $urandom_range(0, tx_gap_max),
                        1'b0);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= data;
        @(posedge clk);
        tracker.set_register(r, data);
    endtask

    // Write every register in index order
    task automatic load_settings(logic [CFG_DATA_W-1:0] vals[REG_COUNT]);
        cfg_reg_t r;
        r = r.first();
        do begin
            write_register(r, vals[r]);
            r = r.next();
        end while (r != r.first());
        cfg_write <= 1'b0;
    endtask

    // Register values mix extremes, small values and full range; upper bits are noise
    function automatic logic [CFG_DATA_W-1:0] pick_register_value(cfg_reg_t r);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        case (r)
            REG_OUTER_ERROR_LIMIT:
                case ($urandom_range(0, 5))
                    0: data[ERR_W-1:0] = 17'h1_0000;
                    1: data[ERR_W-1:0] = 17'h0_ffff;
                    2: data[ERR_W-1:0] = '0;
                    3, 4: data[ERR_W-1:0] = 17'($urandom_range(0, 80)) - 17'd16;
                    default: ;
                endcase
            REG_INTEGRAL_LIMIT:
                case ($urandom_range(0, 5))
                    0: data = 32'h8000_0000;
                    1: data = 32'h7fff_ffff;
                    2: data = $urandom_range(0, 5000);
                    3: data = 32'd0 - $urandom_range(1, 5000);
                    default: ;
                endcase
            default:
                case ($urandom_range(0, 5))
                    0: data[GAIN_W-1:0] = 16'h8000;
                    1: data[GAIN_W-1:0] = 16'h7fff;
                    2: data[GAIN_W-1:0] = '0;
                    3, 4: data[GAIN_W-1:0] = 16'($urandom_range(0, 1024)) - 16'd512;
                    default: ;
                endcase
        endcase
        return data;
    endfunction

    function automatic logic [POS_W-1:0] corner_position();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    // Mix of unrelated positions, near-equal pairs, corners and slow tracking
    task automatic random_phase(int count);
        logic [POS_W-1:0] tgt, meas;
        logic [POS_W-1:0] track_tgt, track_meas;
        track_tgt = $urandom;
        track_meas = track_tgt;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    tgt = $urandom;
                    meas = $urandom;
                end
                1: begin
                    tgt = $urandom;
                    meas = tgt + 16'($urandom_range(0, 32)) - 16'd16;
                end
                2: begin
                    tgt = corner_position();
                    meas = corner_position();
                end
                default: begin
                    tgt = track_tgt + 16'($urandom_range(0, 64)) - 16'd32;
                    meas = track_meas + 16'($urandom_range(0, 16)) - 16'd8;
                end
            endcase
            track_tgt = tgt;
            track_meas = meas;
            send_sample(tgt, meas, $urandom_range(0, tx_gap_max),
                        i == count / 2 || $urandom_range(0, 39) == 0);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] vals[REG_COUNT];
        cfg_reg_t              r;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.target_position = '0;
        in_ch.measured_position = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then the extreme settings
        send_list(opening_samples);
        wait_until_idle();
        load_settings(top_settings);
        send_list(corner_samples);
        wait_until_idle();
        load_settings(bottom_settings);
        send_list(corner_samples);
        wait_until_idle();

        // Random settings per phase; every fourth phase runs without random gaps on either side
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tx_gap_max = (p % 4 == 3) ? 0 : 7;
            rx_gap_max = (p % 4 == 3) ? 0 : 7;
            r = r.first();
            do begin
                vals[r] = pick_register_value(r);
                r = r.next();
            end while (r != r.first());
            load_settings(vals);
            random_phase(PHASE_SAMPLES);
            wait_until_idle();
        end

        // Pin the outer error at its most negative value and walk the outer integral down
        tx_gap_max = 0;
        rx_gap_max = 0;
        load_settings(saturation_settings);
        for (int i = 0; i < SATURATION_RUN; i++)
            send_sample(16'($urandom), 16'($urandom), 0, 1'b0);
        in_ch.valid <= 1'b0;
        wait_until_idle();

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

FILE: cascade_pid_position_rate.f
+incdir+hw/rtl
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_in_if.sv
hw/rtl/cpr_out_if.sv
hw/rtl/cpr_mac.sv
hw/rtl/cascade_pid_position_rate.sv
tb/testbench.sv
